// File: rtl/ddf_pkg.sv
// ----------------------------------------------------------------------------
// ddf_pkg
// Shared types and constants for the decimal digit formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package ddf_pkg;

    // character codes and radix
    localparam logic [7:0]  CODE_ZERO  = 8'd48;
    localparam logic [7:0]  CODE_SPACE = 8'd32;
    localparam logic [15:0] RADIX      = 16'd10;

    // divide by ten as multiply by reciprocal, exact for all 16-bit values
    localparam int          RECIP_SHIFT = 19;
    localparam logic [32:0] RECIP_TEN   = 33'd52429;

    // field widths
    localparam int VALUE_W = 16;
    localparam int CHAR_W  = 8;

    // one quotient bit per divider cycle
    localparam int DIV_STEPS = VALUE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // controller to datapath commands
    typedef struct packed {
        logic load;        // take a new input item
        logic div_start;   // clear remainder, load dividend
        logic div_step;    // one restoring division step
        logic emit;        // load output register
        logic emit_digit;  // with emit: digit (1) or space (0)
        logic div_scale;   // divisor <= divisor / 10
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_digit;    // digit is printed at this place
        logic left_justify;  // suppressed places print a space
        logic out_free;      // output register can take an item
        logic div_last;      // this is the last place (divisor < 10)
    } status_t;

endpackage

`default_nettype wire

// File: rtl/ddf_datapath.sv
// ----------------------------------------------------------------------------
// ddf_datapath
// Value, divisor and flag registers, restoring divider, divide-by-ten
// and the output register of the formatter.
// ----------------------------------------------------------------------------
`default_nettype none

module ddf_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ddf_pkg::cmd_t                      cmd,
    output ddf_pkg::status_t                        status,
    input  wire logic [ddf_pkg::VALUE_W-1:0]        in_value,
    input  wire logic [ddf_pkg::VALUE_W-1:0]        in_divisor,
    input  wire logic                               in_leading_zero,
    input  wire logic                               in_left_justify,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [ddf_pkg::CHAR_W-1:0]              out_char_code,
    output logic                                    out_is_last
);

    logic [ddf_pkg::VALUE_W-1:0] val_reg;
    logic [ddf_pkg::VALUE_W-1:0] div_reg;
    logic                        lead_reg;
    logic                        ljust_reg;
    logic [ddf_pkg::VALUE_W-1:0] rem_reg;
    logic [ddf_pkg::VALUE_W-1:0] quo_reg;
    logic                        ovalid_reg;
    logic [ddf_pkg::CHAR_W-1:0]  char_reg;
    logic                        last_reg;

    logic [ddf_pkg::VALUE_W:0]   trial;
    logic                        trial_ge;
    logic [ddf_pkg::VALUE_W:0]   trial_diff;
    logic [32:0]                 prod;
    logic [ddf_pkg::VALUE_W-1:0] div_tenth;

    // restoring division step: shift in next dividend bit, try subtract
    assign trial      = {rem_reg, quo_reg[ddf_pkg::VALUE_W-1]};
    assign trial_ge   = trial >= {1'b0, div_reg};
    assign trial_diff = trial - {1'b0, div_reg};

    // divisor / 10 by reciprocal multiply
    assign prod      = {17'b0, div_reg} * ddf_pkg::RECIP_TEN;
    assign div_tenth = {2'b0, prod[32:ddf_pkg::RECIP_SHIFT]};

    // status toward controller
    always_comb
    begin
        status.need_digit   = lead_reg || (val_reg >= div_reg)
                              || (div_reg == {{(ddf_pkg::VALUE_W-1){1'b0}}, 1'b1});
        status.left_justify = ljust_reg;
        status.out_free     = !ovalid_reg || out_ready;
        status.div_last     = div_reg < ddf_pkg::RADIX;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg   <= in_value;
            div_reg   <= (in_divisor == '0) ? {{(ddf_pkg::VALUE_W-1){1'b0}}, 1'b1}
                                            : in_divisor;
            lead_reg  <= in_leading_zero;
            ljust_reg <= in_left_justify;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= val_reg;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[ddf_pkg::VALUE_W-1:0]
                                : trial[ddf_pkg::VALUE_W-1:0];
            quo_reg <= {quo_reg[ddf_pkg::VALUE_W-2:0], trial_ge};
        end
        if (cmd.emit && cmd.emit_digit)
        begin
            val_reg  <= rem_reg;
            lead_reg <= 1'b1;
        end
        if (cmd.div_scale)
        begin
            div_reg <= div_tenth;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_reg <= cmd.emit_digit ? ddf_pkg::CODE_ZERO + quo_reg[ddf_pkg::CHAR_W-1:0]
                                       : ddf_pkg::CODE_SPACE;
            // once a digit prints, every later place prints a digit too
            last_reg <= status.div_last;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    assign out_valid     = ovalid_reg;
    assign out_char_code = char_reg;
    assign out_is_last   = last_reg;

endmodule

`default_nettype wire

// File: rtl/ddf_ctrl.sv
// ----------------------------------------------------------------------------
// ddf_ctrl
// Sequencer of the formatter: walks the places, runs the divider
// and hands characters to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ddf_pkg::status_t  status,
    output ddf_pkg::cmd_t          cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_EMIT,
        S_STEP
    } state_t;

    state_t                    state_reg, state_next;
    logic [ddf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      digit_reg, digit_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        digit_next = digit_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.need_digit)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    digit_next    = 1'b1;
                    state_next    = S_DIV;
                end
                else if (status.left_justify)
                begin
                    digit_next = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == ddf_pkg::CNT_W'(ddf_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_digit = digit_reg;
                    state_next     = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.div_scale = 1'b1;
                state_next    = status.div_last ? S_IDLE : S_DECIDE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            digit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/decimal_digit_formatter.sv
// ----------------------------------------------------------------------------
// decimal_digit_formatter
// Writes a 16-bit unsigned value as decimal character codes, one place
// per step from a given place value down to the units.
// ----------------------------------------------------------------------------
//
//  channel   dir  fields (low bit up)
//  s_axis    in   tdata: value[15:0] divisor[31:16] leading_zero[32]
//                        left_justify[33], zero pad [39:34]
//  m_axis    out  tdata: char_code[7:0]; tlast: is_last
//
//  One item at a time; 0 to 5 characters per item.
//  Each printed digit passes decide, the restoring divider, emit and
//  divide-by-ten, a space decide, emit and divide-by-ten, a silent place
//  decide and divide-by-ten; output stalls add to the time of an item.
//  The output register lets the block run ahead by one character;
//  an m_axis stall holds the sequencer in its emit state.
//  Reset clears the sequencer and the output valid; no clearing pass.
//
`default_nettype none

module decimal_digit_formatter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // value, divisor, leading_zero, left_justify
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // char_code
    output logic             m_axis_tlast    // is_last
);

    ddf_pkg::cmd_t    cmd;
    ddf_pkg::status_t status;

    // sequencer
    ddf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .status       (status),
        .cmd          (cmd)
    );

    // datapath
    ddf_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_value        (s_axis_tdata[15:0]),
        .in_divisor      (s_axis_tdata[31:16]),
        .in_leading_zero (s_axis_tdata[32]),
        .in_left_justify (s_axis_tdata[33]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_char_code   (m_axis_tdata),
        .out_is_last     (m_axis_tlast)
    );

    // an emit never overwrites a character still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("emit into occupied output register");

    // datapath commands are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.emit, cmd.div_scale}))
        else $error("overlapping datapath commands");

    // an accepted item closes the input until its places are done
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened right after accept");

endmodule

`default_nettype wire
